// File: src/sdm_pkg.sv
package sdm_pkg;

	// Field and register widths
	localparam int PIX_W   = 8;
	localparam int POS_W   = 6;
	localparam int DIM_W   = 7;
	localparam int HW_W    = 3;
	localparam int CNT_W   = 5;
	localparam int DISP_W  = 4;
	localparam int OFS_W   = 4;
	localparam int SAD_W   = 16;
	localparam int COORD_W = 12;
	localparam int DEN_W   = SAD_W + 2;
	localparam int REM_W   = SAD_W + 3;
	localparam int DSH_W   = SAD_W + 5;
	localparam int QUO_W   = 4;
	localparam int OUT_W   = 8;
	localparam int IDX_W   = 2;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
	localparam logic [IDX_W-1:0] REG_HALF_WINDOW     = 2'd2;
	localparam logic [IDX_W-1:0] REG_DISPARITY_COUNT = 2'd3;

	// Operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_MATCH = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic check;
		logic div;
		logic fix;
		logic emit;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic excluded;
		logic tap_last;
		logic d_last;
		logic refine_ok;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

// File: src/sdm_ram.sv
module sdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/sdm_ctrl.sv
module sdm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          operation,
	input  sdm_pkg::sts_t sts,
	output sdm_pkg::cmd_t cmd
);
	import sdm_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SEARCH = 7'b0000010,
		S_DRAIN  = 7'b0000100,
		S_CHECK  = 7'b0001000,
		S_DIV    = 7'b0010000,
		S_FIX    = 7'b0100000,
		S_RESULT = 7'b1000000
	} state_t;

	state_t state_q, state_nx;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation == OP_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_nx  = sts.excluded ? S_RESULT : S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				cmd.step = 1'b1;
				if (sts.tap_last && sts.d_last) begin
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nx = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_nx  = sts.refine_ok ? S_DIV : S_RESULT;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_last) begin
					state_nx = S_FIX;
				end
			end
			S_FIX: begin
				cmd.fix  = 1'b1;
				state_nx = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// File: src/sdm_dp.sv
module sdm_dp #(
	parameter int MAX_WIDTH       = 64,
	parameter int MAX_HEIGHT      = 64,
	parameter int MAX_DISPARITIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [sdm_pkg::IDX_W-1:0]    wr_index,
	input  logic [sdm_pkg::DIM_W-1:0]    wr_data,
	input  logic [sdm_pkg::POS_W-1:0]    col,
	input  logic [sdm_pkg::POS_W-1:0]    row,
	input  logic [sdm_pkg::PIX_W-1:0]    left_pixel,
	input  logic [sdm_pkg::PIX_W-1:0]    right_pixel,
	input  sdm_pkg::cmd_t                cmd,
	output sdm_pkg::sts_t                sts,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [sdm_pkg::OUT_W-1:0]    disparity
);
	import sdm_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// Configuration registers
	logic [DIM_W-1:0] img_w_q, img_h_q;
	logic [HW_W-1:0]  hw_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= DIM_W'(64);
			img_h_q <= DIM_W'(48);
			hw_q    <= HW_W'(2);
			cnt_q   <= CNT_W'(16);
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:     img_w_q <= wr_data;
				REG_IMAGE_HEIGHT:    img_h_q <= wr_data;
				REG_HALF_WINDOW:     hw_q    <= wr_data[HW_W-1:0];
				REG_DISPARITY_COUNT: cnt_q   <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate width, height and count to their working ranges
	logic signed [COORD_W-1:0] w_c, h_c;
	logic [CNT_W-1:0]          cnt_c;
	logic signed [OFS_W-1:0]   hw_s, hw_neg;

	always_comb begin
		if (img_w_q == '0) begin
			w_c = COORD_W'(1);
		end else if (int'(img_w_q) > MAX_WIDTH) begin
			w_c = COORD_W'(MAX_WIDTH);
		end else begin
			w_c = $signed(COORD_W'(img_w_q));
		end
		if (img_h_q == '0) begin
			h_c = COORD_W'(1);
		end else if (int'(img_h_q) > MAX_HEIGHT) begin
			h_c = COORD_W'(MAX_HEIGHT);
		end else begin
			h_c = $signed(COORD_W'(img_h_q));
		end
		cnt_c  = (int'(cnt_q) > MAX_DISPARITIES) ? CNT_W'(MAX_DISPARITIES) : cnt_q;
		hw_s   = $signed(OFS_W'(hw_q));
		hw_neg = -hw_s;
	end

	// Exclusion test on the incoming match position
	logic signed [COORD_W-1:0] xi, yi;
	assign xi = $signed(COORD_W'(col));
	assign yi = $signed(COORD_W'(row));
	assign sts.excluded = (xi >= w_c) || (yi >= h_c) || (cnt_c == '0) ||
		(xi < $signed(COORD_W'(cnt_c)));

	// Tap counters
	logic [POS_W-1:0]        x_q, y_q;
	logic [DISP_W-1:0]       d_q;
	logic signed [OFS_W-1:0] dx_q, dy_q;

	assign sts.tap_last = (dx_q == hw_s) && (dy_q == hw_s);
	assign sts.d_last   = (CNT_W'(d_q) == cnt_c - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q  <= col;
			y_q  <= row;
			d_q  <= '0;
			dx_q <= hw_neg;
			dy_q <= hw_neg;
		end else if (cmd.step) begin
			if (dx_q == hw_s) begin
				dx_q <= hw_neg;
				if (dy_q == hw_s) begin
					dy_q <= hw_neg;
					d_q  <= d_q + DISP_W'(1);
				end else begin
					dy_q <= dy_q + OFS_W'(1);
				end
			end else begin
				dx_q <= dx_q + OFS_W'(1);
			end
		end
	end

	// Tap coordinates and clipping
	logic signed [COORD_W-1:0] tr, tlc, trc;
	logic                      tap_ok;
	logic [AW-1:0]             raddr_l, raddr_r, waddr;
	logic                      we;

	always_comb begin
		tr  = $signed(COORD_W'(y_q)) + COORD_W'(dy_q);
		tlc = $signed(COORD_W'(x_q)) + COORD_W'(dx_q);
		trc = tlc - $signed(COORD_W'(d_q));
		tap_ok = (tr >= 0) && (tr < h_c) && (tlc >= 0) && (tlc < w_c) &&
			(trc >= 0) && (trc < w_c);
		raddr_l = AW'(AW'(tr) * AW'(MAX_WIDTH) + AW'(tlc));
		raddr_r = AW'(AW'(tr) * AW'(MAX_WIDTH) + AW'(trc));
		waddr   = AW'(AW'(row) * AW'(MAX_WIDTH) + AW'(col));
		we      = cmd.load && (int'(col) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
	end

	// Frame stores
	logic [PIX_W-1:0] lpix, rpix;

	sdm_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_left (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (left_pixel),
		.raddr (raddr_l),
		.rdata (lpix)
	);

	sdm_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_right (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (right_pixel),
		.raddr (raddr_r),
		.rdata (rpix)
	);

	// Tap stage aligned with the read data
	logic              vld_s1, ok_s1, last_s1;
	logic [DISP_W-1:0] d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1   <= tap_ok;
		last_s1 <= sts.tap_last;
		d_s1    <= d_q;
	end

	// Accumulate and keep the best disparity with its neighbor sums
	logic [PIX_W-1:0]  absd;
	logic [SAD_W-1:0]  acc_new;
	logic [SAD_W-1:0]  acc_q, best_q, prev_q, s0_q, s2_q;
	logic [DISP_W-1:0] bd_q;

	assign absd    = (lpix > rpix) ? lpix - rpix : rpix - lpix;
	assign acc_new = acc_q + (ok_s1 ? SAD_W'(absd) : '0);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q  <= '0;
			best_q <= '1;
			bd_q   <= '0;
		end else if (vld_s1) begin
			if (last_s1) begin
				acc_q  <= '0;
				prev_q <= acc_new;
				if (acc_new < best_q) begin
					best_q <= acc_new;
					bd_q   <= d_s1;
					s0_q   <= prev_q;
				end else if (d_s1 == bd_q + DISP_W'(1)) begin
					s2_q <= acc_new;
				end
			end else begin
				acc_q <= acc_new;
			end
		end
	end

	// Refinement setup
	logic signed [DEN_W-1:0] den;
	logic [SAD_W-1:0]        mag;

	always_comb begin
		den = $signed(DEN_W'(s0_q)) + $signed(DEN_W'(s2_q)) -
			($signed(DEN_W'(best_q)) <<< 1);
		mag = (s0_q >= s2_q) ? s0_q - s2_q : s2_q - s0_q;
	end

	assign sts.refine_ok = (bd_q != '0) && ((CNT_W'(bd_q) + CNT_W'(1)) < cnt_c) &&
		(den > 0);

	// Restoring division, one quotient bit a cycle
	logic [DEN_W-2:0]  den_q;
	logic [REM_W-1:0]  rem_q;
	logic              neg_q;
	logic [1:0]        qbit_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DSH_W-1:0]  dsh;
	logic [OUT_W-1:0]  res_q;

	assign dsh          = DSH_W'(den_q) << qbit_q;
	assign sts.div_last = (qbit_q == 2'd0);

	// Final value with clamp
	logic signed [QUO_W+1:0] sub;
	logic signed [9:0]       v;

	always_comb begin
		sub = $signed({2'b00, quo_q});
		if (neg_q) begin
			sub = -sub;
		end
		v = $signed({2'b00, bd_q, 4'b0000}) + 10'(sub);
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_q <= '0;
		end
		if (cmd.check) begin
			res_q  <= {bd_q, 4'b0000};
			den_q  <= den[DEN_W-2:0];
			rem_q  <= {mag, 3'b000};
			neg_q  <= (s2_q > s0_q);
			qbit_q <= 2'd3;
			quo_q  <= '0;
		end
		if (cmd.div) begin
			if (DSH_W'(rem_q) >= dsh) begin
				rem_q         <= REM_W'(DSH_W'(rem_q) - dsh);
				quo_q[qbit_q] <= 1'b1;
			end
			qbit_q <= qbit_q - 2'd1;
		end
		if (cmd.fix) begin
			if (v < 0) begin
				res_q <= '0;
			end else if (v > 10'sd255) begin
				res_q <= 8'hFF;
			end else begin
				res_q <= v[OUT_W-1:0];
			end
		end
	end

	// Output register
	logic out_valid_q;
	logic [OUT_W-1:0] disp_q;

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign disparity    = disp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			disp_q <= res_q;
		end
	end

endmodule

// File: src/sad_stereo_disparity_match_unit.sv
// Stereo disparity matcher: block matching by sum of absolute differences
// with parabolic sub-pixel refinement, result in 4.4 fixed point.
// Input channel (in_valid/in_stall): operation 0 writes left_pixel and
// right_pixel at (col,row) into the two frame stores and gives no result;
// operation 1 matches the pixel at (col,row) and gives one result.
// Output channel (out_valid/out_stall) carries disparity from an output
// register, so the next item is taken while a result waits for transfer.
// A match searches every window tap of every disparity through one read
// port of each frame store, one tap a cycle, then refines when it can; a
// position that is excluded skips the search and goes straight to its result.
// Items are handled one at a time; in_stall is high while a match is busy
// and while its result cannot enter a full, stalled output register.
// Reset clears the controller and output valid and loads the registers
// with width 64, height 48, half window 2, count 16; frame stores are not
// cleared and must be written before they are matched.
// The user must write registers through wr_en/wr_index/wr_data only while idle; the block does not enforce it.
module sad_stereo_disparity_match_unit #(
	parameter int MAX_WIDTH       = 64,
	parameter int MAX_HEIGHT      = 64,
	parameter int MAX_DISPARITIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [sdm_pkg::IDX_W-1:0] wr_index,
	input  logic [sdm_pkg::DIM_W-1:0] wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [sdm_pkg::POS_W-1:0] col,
	input  logic [sdm_pkg::POS_W-1:0] row,
	input  logic [sdm_pkg::PIX_W-1:0] left_pixel,
	input  logic [sdm_pkg::PIX_W-1:0] right_pixel,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [sdm_pkg::OUT_W-1:0] disparity
);
	import sdm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	sdm_dp #(
		.MAX_WIDTH       (MAX_WIDTH),
		.MAX_HEIGHT      (MAX_HEIGHT),
		.MAX_DISPARITIES (MAX_DISPARITIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.col         (col),
		.row         (row),
		.left_pixel  (left_pixel),
		.right_pixel (right_pixel),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.disparity   (disparity)
	);

endmodule
